// ===== rtl/slci_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slci_pkg
// Types, character codes and sizes shared by the serial LED command
// interpreter modules.
// ----------------------------------------------------------------------------
package slci_pkg;

	// Defaults for the top-level parameters.
	localparam int CMD_BUFFER_DEPTH_DEF = 32;
	localparam int SENSOR_BITS_DEF      = 10;
	localparam int FIELD_BITS_DEF       = 16;

	// Width of the sensor sample field on the input channel.
	localparam int SENSOR_W = 10;
	// Width of the decimal conversion datapath; holds values up to 16383, and four digits cover up to 9999.
	localparam int DEC_W = 14;
	// Number of jobs held between the front and the back.
	localparam int QUEUE_DEPTH = 2;

	// Event codes carried in the func field.
	localparam logic [1:0] FUNC_BYTE   = 2'd0;
	localparam logic [1:0] FUNC_SENSOR = 2'd1;
	localparam logic [1:0] FUNC_TICK   = 2'd2;

	// Character codes.
	localparam logic [7:0] CH_QUERY = 8'h3F;
	localparam logic [7:0] CH_L_UP  = 8'h4C;
	localparam logic [7:0] CH_L_LO  = 8'h6C;
	localparam logic [7:0] CH_B_UP  = 8'h42;
	localparam logic [7:0] CH_B_LO  = 8'h62;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;

	typedef struct packed {
		logic [1:0]          func;
		logic [7:0]          rx_byte;
		logic [SENSOR_W-1:0] sensor_sample;
	} in_item_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       led_on;
		logic       last;
	} out_item_t;

	// What the back end has to do for one accepted request.
	typedef enum logic [1:0] {
		JOB_STATUS = 2'd0,
		JOB_CHAR   = 2'd1,
		JOB_DIGITS = 2'd2
	} job_kind_t;

	typedef struct packed {
		job_kind_t        kind;
		logic [7:0]       tx_byte;
		logic [DEC_W-1:0] value;
		logic             led_on;
	} job_t;

endpackage
`default_nettype wire

// ===== rtl/slci_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slci_front
// Accepts requests, updates the LED, sensor, command parser and blink
// sequencer state, and queues one job per request for the back end.
// ----------------------------------------------------------------------------
module slci_front import slci_pkg::*; #(
	parameter int CMD_BUFFER_DEPTH = CMD_BUFFER_DEPTH_DEF,
	parameter int SENSOR_BITS      = SENSOR_BITS_DEF,
	parameter int FIELD_BITS       = FIELD_BITS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_item_t in_item,
	input  wire logic     queue_full,
	output logic          push,
	output job_t          push_job
);

	localparam int LEN_W = $clog2(CMD_BUFFER_DEPTH);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(CMD_BUFFER_DEPTH - 1);
	localparam logic [SENSOR_W-1:0] SENSOR_MASK =
		(SENSOR_BITS >= SENSOR_W) ? {SENSOR_W{1'b1}} : SENSOR_W'((1 << SENSOR_BITS) - 1);

	logic                  led_q, led_d;
	logic [SENSOR_W-1:0]   sensor_q, sensor_d;
	logic [LEN_W-1:0]      len_q, len_d;
	logic [1:0]            phase_q, phase_d;
	logic                  stopped_q, stopped_d;
	logic [FIELD_BITS-1:0] count_q, count_d;
	logic [FIELD_BITS-1:0] on_q, on_d;
	logic [FIELD_BITS-1:0] off_q, off_d;
	logic                  busy_q, busy_d;
	logic                  gap_q, gap_d;
	logic [FIELD_BITS-1:0] ticks_q, ticks_d;
	logic [FIELD_BITS-1:0] blinks_q, blinks_d;

	logic                  pulse;
	logic [FIELD_BITS-1:0] ticks_dec;
	logic [FIELD_BITS-1:0] blinks_dec;
	logic                  is_digit;
	logic [3:0]            digit_val;
	job_kind_t             kind;
	logic [7:0]            reply;

	function automatic logic [FIELD_BITS-1:0] add_digit(input logic [FIELD_BITS-1:0] v,
			input logic [3:0] d);
		logic [FIELD_BITS+2:0] s;
		s = {v, 3'b000} + (FIELD_BITS+3)'({v, 1'b0}) + (FIELD_BITS+3)'(d);
		return s[FIELD_BITS-1:0];
	endfunction

	assign in_ready  = !queue_full;
	assign push      = in_valid && in_ready;
	assign is_digit  = (in_item.rx_byte >= CH_ZERO) && (in_item.rx_byte <= CH_NINE);
	assign digit_val = 4'(in_item.rx_byte - CH_ZERO);

	always_comb begin
		led_d      = led_q;
		sensor_d   = sensor_q;
		len_d      = len_q;
		phase_d    = phase_q;
		stopped_d  = stopped_q;
		count_d    = count_q;
		on_d       = on_q;
		off_d      = off_q;
		busy_d     = busy_q;
		gap_d      = gap_q;
		ticks_d    = ticks_q;
		blinks_d   = blinks_q;
		pulse      = 1'b0;
		ticks_dec  = (ticks_q != '0) ? ticks_q - 1'b1 : '0;
		blinks_dec = (blinks_q != '0) ? blinks_q - 1'b1 : '0;
		kind       = JOB_STATUS;
		reply      = '0;
		case (in_item.func)
			FUNC_SENSOR: begin
				sensor_d = in_item.sensor_sample & SENSOR_MASK;
			end
			FUNC_TICK: begin
				if (busy_q) begin
					ticks_d = ticks_dec;
					if (ticks_dec == '0) begin
						if (gap_q) begin
							pulse = 1'b1;
						end else begin
							led_d    = 1'b0;
							blinks_d = blinks_dec;
							if (blinks_dec == '0) begin
								busy_d = 1'b0;
							end else if (off_q == '0) begin
								pulse = 1'b1;
							end else begin
								gap_d   = 1'b1;
								ticks_d = off_q;
							end
						end
					end
				end
			end
			FUNC_BYTE: begin
				if (!busy_q) begin
					if (len_q != '0) begin
						if (in_item.rx_byte == CH_CR || in_item.rx_byte == CH_LF) begin
							len_d = '0;
							if (count_q != '0) begin
								busy_d   = 1'b1;
								blinks_d = count_q;
								pulse    = 1'b1;
							end
						end else if (len_q < LEN_MAX) begin
							len_d = len_q + 1'b1;
							if (!stopped_q && phase_q <= 2'd2) begin
								if (is_digit) begin
									case (phase_q)
										2'd0:    count_d = add_digit(count_q, digit_val);
										2'd1:    on_d    = add_digit(on_q, digit_val);
										default: off_d   = add_digit(off_q, digit_val);
									endcase
								end else if (in_item.rx_byte == CH_COMMA && phase_q < 2'd2) begin
									phase_d = phase_q + 1'b1;
								end else begin
									stopped_d = 1'b1;
								end
							end
						end
					end else begin
						case (in_item.rx_byte)
							CH_ONE:  led_d = 1'b1;
							CH_ZERO: led_d = 1'b0;
							CH_QUERY: begin
								kind  = JOB_CHAR;
								reply = led_q ? CH_ONE : CH_ZERO;
							end
							CH_L_UP, CH_L_LO: begin
								kind = JOB_DIGITS;
							end
							CH_B_UP, CH_B_LO: begin
								len_d     = LEN_W'(1);
								phase_d   = 2'd0;
								stopped_d = 1'b0;
								count_d   = '0;
								on_d      = '0;
								off_d     = '0;
							end
							default: ;
						endcase
					end
				end
			end
			default: ;
		endcase
		// Start of a pulse; an on time of zero finishes the whole sequence.
		if (pulse) begin
			if (on_q == '0) begin
				led_d    = 1'b0;
				busy_d   = 1'b0;
				gap_d    = 1'b0;
				ticks_d  = '0;
				blinks_d = '0;
			end else begin
				led_d   = 1'b1;
				gap_d   = 1'b0;
				ticks_d = on_q;
			end
		end
	end

	always_comb begin
		push_job.kind    = kind;
		push_job.tx_byte = reply;
		push_job.value   = DEC_W'(sensor_q);
		push_job.led_on  = led_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_q     <= 1'b0;
			sensor_q  <= '0;
			len_q     <= '0;
			phase_q   <= 2'd0;
			stopped_q <= 1'b0;
			count_q   <= '0;
			on_q      <= '0;
			off_q     <= '0;
			busy_q    <= 1'b0;
			gap_q     <= 1'b0;
			ticks_q   <= '0;
			blinks_q  <= '0;
		end else if (push) begin
			led_q     <= led_d;
			sensor_q  <= sensor_d;
			len_q     <= len_d;
			phase_q   <= phase_d;
			stopped_q <= stopped_d;
			count_q   <= count_d;
			on_q      <= on_d;
			off_q     <= off_d;
			busy_q    <= busy_d;
			gap_q     <= gap_d;
			ticks_q   <= ticks_d;
			blinks_q  <= blinks_d;
		end
	end

	// An idle sequencer leaves no gap or countdown behind.
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (!gap_q && ticks_q == '0))
		else $error("blink sequencer idle with gap or ticks pending");

endmodule
`default_nettype wire

// ===== rtl/slci_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slci_queue
// Short job queue between the front and the back, so that either side
// can stall without holding up the other until the queue is full.
// ----------------------------------------------------------------------------
module slci_queue import slci_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	output logic      full,
	input  wire logic pop,
	output logic      empty,
	output job_t      head
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	job_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push |-> !full) and (pop |-> !empty))
		else $error("job queue pushed when full or popped when empty");

endmodule
`default_nettype wire

// ===== rtl/slci_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slci_back
// Takes jobs from the queue and delivers results: a status result, a
// single reply character, or the sensor value as decimal digits, one
// digit per cycle while the output is not stalled, most significant first.
// ----------------------------------------------------------------------------
module slci_back import slci_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic empty,
	input  wire job_t head,
	output logic      pop,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_item_t out_item
);

	logic             out_valid_q;
	out_item_t        out_q;
	logic             working_q;
	logic [DEC_W-1:0] rem_q;
	logic [1:0]       pos_q;
	logic             job_led_q;

	logic             adv;
	logic [DEC_W-1:0] src_rem;
	logic [1:0]       start_pos;
	logic [1:0]       src_pos;
	logic [DEC_W-1:0] weight;
	logic [3:0]       dig;
	logic [DEC_W-1:0] sub;
	logic [7:0]       dig_char;

	assign adv = !out_valid_q || out_ready;
	assign pop = adv && !working_q && !empty;

	always_comb begin
		if (head.value >= DEC_W'(1000)) begin
			start_pos = 2'd3;
		end else if (head.value >= DEC_W'(100)) begin
			start_pos = 2'd2;
		end else if (head.value >= DEC_W'(10)) begin
			start_pos = 2'd1;
		end else begin
			start_pos = 2'd0;
		end
	end

	assign src_rem = working_q ? rem_q : head.value;
	assign src_pos = working_q ? pos_q : start_pos;

	always_comb begin
		case (src_pos)
			2'd0:    weight = DEC_W'(1);
			2'd1:    weight = DEC_W'(10);
			2'd2:    weight = DEC_W'(100);
			default: weight = DEC_W'(1000);
		endcase
	end

	// The digit is the largest factor, up to nine, by which the current weight still fits.
	always_comb begin
		dig = '0;
		sub = '0;
		for (int k = 1; k <= 9; k++) begin
			if (src_rem >= DEC_W'(k) * weight) begin
				dig = 4'(k);
				sub = DEC_W'(k) * weight;
			end
		end
	end

	assign dig_char = CH_ZERO + {4'b0000, dig};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			working_q   <= 1'b0;
		end else if (adv) begin
			if (working_q) begin
				out_valid_q <= 1'b1;
				working_q   <= (pos_q != 2'd0);
			end else if (!empty) begin
				out_valid_q <= 1'b1;
				working_q   <= (head.kind == JOB_DIGITS) && (start_pos != 2'd0);
			end else begin
				out_valid_q <= 1'b0;
				working_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_q <= src_rem - sub;
			pos_q <= src_pos - 2'd1;
			if (working_q) begin
				out_q <= '{tx_valid: 1'b1, tx_byte: dig_char, led_on: job_led_q,
					last: (pos_q == 2'd0)};
			end else begin
				job_led_q <= head.led_on;
				case (head.kind)
					JOB_CHAR: begin
						out_q <= '{tx_valid: 1'b1, tx_byte: head.tx_byte,
							led_on: head.led_on, last: 1'b1};
					end
					JOB_DIGITS: begin
						out_q <= '{tx_valid: 1'b1, tx_byte: dig_char,
							led_on: head.led_on, last: (start_pos == 2'd0)};
					end
					default: begin
						out_q <= '{tx_valid: 1'b0, tx_byte: 8'h00,
							led_on: head.led_on, last: 1'b1};
					end
				endcase
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	a_digits_pending: assert property (@(posedge clk) disable iff (!arst_n)
		working_q |-> (out_valid_q && out_q.tx_valid && !out_q.last))
		else $error("digits pending but shown result is not an open digit");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		working_q |-> ((pos_q == 2'd0 && rem_q < DEC_W'(10)) ||
			(pos_q == 2'd1 && rem_q < DEC_W'(100)) ||
			(pos_q == 2'd2 && rem_q < DEC_W'(1000)) ||
			(pos_q == 2'd3 && rem_q < DEC_W'(10000))))
		else $error("remainder too large for remaining digits");

	a_status_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.tx_valid) |-> (out_q.last && out_q.tx_byte == 8'h00))
		else $error("status result not final or carries a character");

endmodule
`default_nettype wire

// ===== rtl/serial_led_command_interpreter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// serial_led_command_interpreter
// Interprets received serial bytes, sensor samples and millisecond ticks,
// drives the LED and returns reply characters.
// ----------------------------------------------------------------------------
// A request is taken whenever the two-entry job queue has room, so requests
// can arrive back to back. Each request yields one result, except a sensor
// query, which yields one result per decimal digit (one to four); the back
// end emits one result per cycle while the output is not stalled. The final
// result of each request carries last. New requests are held off only while
// the queue is full, as when the output stalls or digits are still pending.
module serial_led_command_interpreter import slci_pkg::*; #(
	parameter int CMD_BUFFER_DEPTH = CMD_BUFFER_DEPTH_DEF,
	parameter int SENSOR_BITS      = SENSOR_BITS_DEF,
	parameter int FIELD_BITS       = FIELD_BITS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_item,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_item
);

	logic queue_full;
	logic queue_empty;
	logic push;
	logic pop;
	job_t push_job;
	job_t head_job;

	slci_front #(
		.CMD_BUFFER_DEPTH (CMD_BUFFER_DEPTH),
		.SENSOR_BITS      (SENSOR_BITS),
		.FIELD_BITS       (FIELD_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.queue_full (queue_full),
		.push       (push),
		.push_job   (push_job)
	);

	slci_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (queue_full),
		.pop      (pop),
		.empty    (queue_empty),
		.head     (head_job)
	);

	slci_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (queue_empty),
		.head      (head_job),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule
`default_nettype wire

// ===== bench/tb_serial_led_command_interpreter.sv =====
// ----------------------------------------------------------------------------
// tb_serial_led_command_interpreter
// Self-checking bench for the serial LED command interpreter. Serial bytes,
// sensor samples and millisecond ticks are sent as requests. A built-in
// predictor follows the LED, the sensor value, the blink command parser and
// the blink sequence, and works out the replies that each request causes.
// Every result from the block is checked against them in order. The random
// part sends blink commands most often, with random fields, and then enough ticks
// to finish each sequence. Sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module tb_serial_led_command_interpreter import slci_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int         ITEM_TARGET = 450;
	localparam int         CYCLE_LIMIT = 300000;

	typedef enum bit [1:0] {
		FIELD_COUNT,
		FIELD_ON,
		FIELD_OFF
	} blink_field_t;

	class led_cmd_scoreboard;
		bit           led;
		bit [9:0]     sensor;
		int           cmd_len;
		blink_field_t field;
		bit           parse_stopped;
		bit [15:0]    blink_count;
		bit [15:0]    on_ticks;
		bit [15:0]    off_ticks;
		bit           busy;
		bit           in_gap;
		bit [15:0]    ticks_left;
		bit [15:0]    blinks_left;
		out_item_t    replies[$];
		int           errors;

		function out_item_t reply_item(bit valid, logic [7:0] c);
			out_item_t r;
			r.tx_valid = valid;
			r.tx_byte  = valid ? c : 8'h00;
			r.led_on   = led;
			r.last     = 1'b0;
			return r;
		endfunction

		function void parse_char(logic [7:0] c);
			if (parse_stopped)
				return;
			if (c >= CH_ZERO && c <= CH_NINE) begin
				case (field)
					FIELD_COUNT: blink_count = blink_count * 16'd10 + 16'(c - CH_ZERO);
					FIELD_ON:    on_ticks = on_ticks * 16'd10 + 16'(c - CH_ZERO);
					default:     off_ticks = off_ticks * 16'd10 + 16'(c - CH_ZERO);
				endcase
			end else if (c == CH_COMMA && field != FIELD_OFF) begin
				field = (field == FIELD_COUNT) ? FIELD_ON : FIELD_OFF;
			end else begin
				parse_stopped = 1'b1;
			end
		endfunction

		// A pulse with no on time ends the whole sequence at once.
		function void start_pulse();
			if (on_ticks == 16'd0) begin
				led         = 1'b0;
				busy        = 1'b0;
				in_gap      = 1'b0;
				ticks_left  = 16'd0;
				blinks_left = 16'd0;
				return;
			end
			led        = 1'b1;
			in_gap     = 1'b0;
			ticks_left = on_ticks;
		endfunction

		function void advance_tick();
			if (!busy)
				return;
			if (ticks_left != 16'd0)
				ticks_left--;
			if (ticks_left != 16'd0)
				return;
			if (in_gap) begin
				start_pulse();
				return;
			end
			led = 1'b0;
			if (blinks_left != 16'd0)
				blinks_left--;
			if (blinks_left == 16'd0) begin
				busy = 1'b0;
				return;
			end
			if (off_ticks == 16'd0) begin
				start_pulse();
			end else begin
				in_gap     = 1'b1;
				ticks_left = off_ticks;
			end
		endfunction

		function void note_request(in_item_t it);
			out_item_t   res[$];
			out_item_t   tail;
			logic [7:0]  c;
			logic [7:0]  digs[4];
			int unsigned v;
			int          ndig;
			c = it.rx_byte;
			case (it.func)
				FUNC_SENSOR: sensor = it.sensor_sample;
				FUNC_TICK:   advance_tick();
				FUNC_BYTE: begin
					if (!busy) begin
						if (cmd_len > 0) begin
							if (c == CH_LF || c == CH_CR) begin
								cmd_len = 0;
								if (blink_count != 16'd0) begin
									busy        = 1'b1;
									blinks_left = blink_count;
									start_pulse();
								end
							end else if (cmd_len < CMD_BUFFER_DEPTH_DEF - 1) begin
								cmd_len++;
								parse_char(c);
							end
						end else if (c == CH_ONE) begin
							led = 1'b1;
						end else if (c == CH_ZERO) begin
							led = 1'b0;
						end else if (c == CH_QUERY) begin
							res.push_back(reply_item(1'b1, led ? CH_ONE : CH_ZERO));
						end else if (c == CH_L_UP || c == CH_L_LO) begin
							v    = (sensor > 9999) ? 9999 : sensor;
							ndig = 0;
							do begin
								digs[ndig] = CH_ZERO + 8'(v % 10);
								ndig++;
								v = v / 10;
							end while (v > 0 && ndig < 4);
							while (ndig > 0) begin
								ndig--;
								res.push_back(reply_item(1'b1, digs[ndig]));
							end
						end else if (c == CH_B_UP || c == CH_B_LO) begin
							cmd_len       = 1;
							field         = FIELD_COUNT;
							parse_stopped = 1'b0;
							blink_count   = 16'd0;
							on_ticks      = 16'd0;
							off_ticks     = 16'd0;
						end
					end
				end
				default: ;
			endcase
			if (res.size() == 0)
				res.push_back(reply_item(1'b0, 8'h00));
			tail      = res.pop_back();
			tail.last = 1'b1;
			res.push_back(tail);
			foreach (res[i])
				replies.push_back(res[i]);
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (replies.size() == 0) begin
				$error("unexpected result: tx_valid %0d tx_byte 0x%02h led_on %0d last %0d",
					got.tx_valid, got.tx_byte, got.led_on, got.last);
				errors++;
				return;
			end
			want = replies.pop_front();
			if (got.tx_valid !== want.tx_valid) begin
				$error("tx_valid: expected %0d, actual %0d", want.tx_valid, got.tx_valid);
				errors++;
			end
			if (got.tx_byte !== want.tx_byte) begin
				$error("tx_byte: expected 0x%02h, actual 0x%02h", want.tx_byte, got.tx_byte);
				errors++;
			end
			if (got.led_on !== want.led_on) begin
				$error("led_on: expected %0d, actual %0d", want.led_on, got.led_on);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, actual %0d", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      out_ready = 1'b0;
	in_item_t  in_item   = '0;
	logic      in_ready;
	logic      out_valid;
	out_item_t out_item;

	led_cmd_scoreboard sb;
	// Follows the requests in the order they are sent, so that the stimulus
	// can see whether a blink sequence is still running.
	led_cmd_scoreboard shadow;

	int idle_pct  = 0;
	int stall_pct = 0;
	int counted   = 0;
	int cycles    = 0;

	serial_led_command_interpreter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Requests are noted before results, so a result in the same cycle as
	// its request would still find its expectation.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_request(in_item);
			if (out_valid && out_ready)
				sb.check_result(out_item);
		end
	end

	function automatic in_item_t make_request(logic [1:0] f, logic [7:0] c, logic [9:0] s);
		in_item_t it;
		it.func          = f;
		it.rx_byte       = c;
		it.sensor_sample = s;
		return it;
	endfunction

	task automatic send_request(input in_item_t it);
		if (it.func == FUNC_SENSOR || (it.func == FUNC_TICK && shadow.busy) ||
				(it.func == FUNC_BYTE && !shadow.busy))
			counted++;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		shadow.note_request(it);
		shadow.replies.delete();
	endtask

	task automatic send_byte(input logic [7:0] c);
		send_request(make_request(FUNC_BYTE, c, 10'($urandom)));
	endtask

	task automatic send_tick();
		send_request(make_request(FUNC_TICK, 8'($urandom), 10'($urandom)));
	endtask

	task automatic send_sample(input logic [9:0] s);
		send_request(make_request(FUNC_SENSOR, 8'($urandom), s));
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	function automatic string num_text(input int unsigned v);
		string z;
		z = "";
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(1, 3)) z = {z, "0"};
		return {z, $sformatf("%0d", v)};
	endfunction

	// Builds one blink command, sends it and then ticks until the sequence
	// is over, with the odd byte or sample in between.
	task automatic blink_command();
		string      body;
		int         mode;
		int         p;
		logic [7:0] junk;
		mode = $urandom_range(99);
		body = $sformatf("%s,%s,%s", num_text($urandom_range(0, 4)),
			num_text($urandom_range(0, 5)), num_text($urandom_range(0, 4)));
		if (mode < 50) begin
			// keep the plain command
		end else if (mode < 65) begin
			// Field values that wrap round to small ones.
			body = $sformatf("%0d,%0d,%0d", $urandom_range(1, 3) + 65536 * $urandom_range(1, 9),
				$urandom_range(1, 3), $urandom_range(0, 3) + 65536 * $urandom_range(1, 9));
		end else if (mode < 75) begin
			if ($urandom_range(1))
				body = $urandom_range(1) ? $sformatf("%0d,0,%0d", $urandom_range(65535),
					$urandom_range(65535)) : $sformatf("%0d", $urandom_range(65535));
			else
				body = $sformatf("0,%0d,%0d", $urandom, $urandom);
		end else if (mode < 90) begin
			// A stray character lands at a random place; most kinds stop the parse there.
			case ($urandom_range(4))
				0:       junk = CH_B_UP;
				1:       junk = CH_QUERY;
				2:       junk = CH_L_LO;
				3:       junk = CH_COMMA;
				default: junk = 8'($urandom);
			endcase
			if (junk >= CH_ZERO && junk <= CH_NINE)
				junk = 8'h78;
			p    = $urandom_range(0, body.len());
			body = {body.substr(0, p - 1), $sformatf("%c", junk), body.substr(p, body.len() - 1)};
		end else if (mode < 95) begin
			body = body.substr(0, $urandom_range(0, body.len() - 1));
		end else begin
			// Often longer than the command buffer holds.
			body = "";
			repeat ($urandom_range(24, 40)) body = {body, "0"};
			body = {body, "3,2,1"};
		end
		send_byte($urandom_range(1) ? CH_B_UP : CH_B_LO);
		send_text(body);
		send_byte($urandom_range(1) ? CH_CR : CH_LF);
		while (shadow.busy) begin
			p = $urandom_range(99);
			if (p < 6)
				send_byte($urandom_range(1) ? CH_ONE : CH_L_UP);
			else if (p < 10)
				send_sample(10'($urandom));
			else
				send_tick();
		end
	endtask

	task automatic random_step();
		int         r;
		logic [7:0] c;
		logic [1:0] f;
		r = $urandom_range(99);
		if (r < 45) begin
			blink_command();
		end else if (r < 60) begin
			case ($urandom_range(4))
				0:       send_byte(CH_ONE);
				1:       send_byte(CH_ZERO);
				2:       send_byte(CH_QUERY);
				3:       send_byte(CH_L_UP);
				default: send_byte(CH_L_LO);
			endcase
		end else if (r < 72) begin
			case ($urandom_range(9))
				0:       send_sample(10'd0);
				1:       send_sample(10'd1023);
				2:       send_sample(10'd9);
				3:       send_sample(10'd10);
				4:       send_sample(10'd99);
				5:       send_sample(10'd100);
				6:       send_sample(10'd999);
				7:       send_sample(10'd1000);
				default: send_sample(10'($urandom));
			endcase
		end else if (r < 82) begin
			repeat ($urandom_range(1, 3)) send_tick();
		end else begin
			// Noise never opens a command, so no sequence can grow too long.
			f = 2'($urandom);
			c = 8'($urandom);
			if (c == CH_B_UP || c == CH_B_LO)
				c = 8'hFF;
			send_request(make_request(f, c, 10'($urandom)));
		end
	endtask

	initial begin
		sb     = new();
		shadow = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_byte(CH_QUERY);
		send_byte(CH_ONE);
		send_byte(CH_QUERY);
		send_byte(CH_ZERO);
		send_tick();
		send_request(make_request(FUNC_UNUSED, 8'($urandom), 10'($urandom)));
		send_byte(CH_LF);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_sample(10'd0);
		send_byte(CH_L_UP);
		send_sample(10'd1023);
		send_byte(CH_L_LO);
		send_sample(10'd7);
		send_byte(CH_L_UP);
		send_text("b2,1,0");
		send_byte(CH_CR);
		send_tick();
		send_byte(CH_ONE);
		send_sample(10'd100);
		send_tick();
		send_byte(CH_L_UP);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0:       begin idle_pct = 0;  stall_pct = 0;  end
				1:       begin idle_pct = 63; stall_pct = 0;  end
				2:       begin idle_pct = 0;  stall_pct = 63; end
				default: begin idle_pct = 7;  stall_pct = 7;  end
			endcase
			while (counted < (ph + 1) * ITEM_TARGET / 4)
				random_step();
		end
		in_valid <= 1'b0;

		while (sb.replies.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.replies.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/slci_pkg.sv
rtl/slci_front.sv
rtl/slci_queue.sv
rtl/slci_back.sv
rtl/serial_led_command_interpreter.sv
bench/tb_serial_led_command_interpreter.sv
